// ----- design/lsgh_pkg.sv -----
// Shared types and codes of the LCD scan gray history block.
package lsgh_pkg;

  localparam int ADDR_W    = 20;
  localparam int LINE_W    = 6;
  localparam int COL_W     = 8;
  localparam int LANES     = 4;
  localparam logic [ADDR_W-1:0] LINE_STEP = 20'h00022;
  localparam logic [ADDR_W-1:0] SKIP_STEP = 20'h00002;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_GROUP = 2'd1,
    KIND_NONE  = 2'd2
  } lsgh_kind_t;

  typedef enum logic [2:0] {
    REG_SCREEN_BASE = 3'd0,
    REG_MENU_START  = 3'd1,
    REG_LINE_STRIDE = 3'd2,
    REG_MAIN_HEIGHT = 3'd3,
    REG_PIXEL_SHIFT = 3'd4
  } lsgh_reg_t;

  // One result word in flight, before the gray levels are known.
  typedef struct packed {
    lsgh_kind_t        kind;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [2:0]        cnt;
    logic [LANES-1:0]  cur;
    logic              gray_en;
    logic              line_done;
    logic              frame_done;
  } lsgh_item_t;

endpackage

// ----- design/lsgh_bank.sv -----
// One bank of the pixel history store: one write port, one registered read port.
module lsgh_bank #(
  parameter int DEPTH = 2096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [3:0]    rdata
);
  logic [3:0] mem [DEPTH];
  logic [3:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- design/lsgh_scan.sv -----
// Scan sequencer: configuration registers, line and column state, store index.
module lsgh_scan #(
  parameter int LINE_PIXELS = 131,
  parameter int LINE_COUNT  = 64,
  parameter int IW          = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [19:0]              cfg_data,
  input  logic                     acc,
  input  logic                     mode,
  input  logic [3:0]               nibble,
  input  logic                     display_on,
  output lsgh_pkg::lsgh_item_t     item,
  output logic [IW-1:0]            idx
);
  import lsgh_pkg::*;

  localparam int LW   = (LINE_COUNT > 2) ? $clog2(LINE_COUNT) : 1;
  localparam int CW   = $clog2(LINE_PIXELS + 1);
  localparam int HW   = (LW > LINE_W) ? LW : LINE_W;

  logic [ADDR_W-1:0] screen_base_r, menu_start_r, line_stride_r;
  logic [5:0]        main_height_r;
  logic [2:0]        pixel_shift_r;

  logic [LW-1:0]     scan_line_r, scan_line_nxt;
  logic              menu_r, menu_nxt;
  logic [ADDR_W-1:0] line_addr_r, line_addr_nxt;
  logic              off_r, off_nxt;
  logic [CW-1:0]     column_r, column_nxt;
  logic [2:0]        nsk_r, nsk_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              gray_en_r, gray_en_nxt;
  logic              active_r, active_nxt;
  logic              skip_r, skip_nxt;

  logic [1:0]        start;
  logic [2:0]        cnt4, cnt;
  logic [CW:0]       left_w, col_new;
  logic [3:0]        shifted;
  logic [ADDR_W-1:0] next_addr;
  logic [LW-1:0]     sl;
  logic              mn;
  logic [ADDR_W-1:0] la;
  logic [2:0]        nsk;

  assign idx = IW'(scan_line_r * LINE_PIXELS + column_r);

  always_comb begin
    scan_line_nxt = scan_line_r;
    menu_nxt      = menu_r;
    line_addr_nxt = line_addr_r;
    off_nxt       = off_r;
    column_nxt    = column_r;
    nsk_nxt       = nsk_r;
    phase_nxt     = phase_r;
    gray_en_nxt   = gray_en_r;
    active_nxt    = active_r;
    skip_nxt      = skip_r;
    item          = '0;
    item.kind     = KIND_NONE;
    sl            = scan_line_r;
    mn            = menu_r;
    la            = line_addr_r;
    nsk           = 3'd0;
    start         = (column_r == '0) ? nsk_r[1:0] : 2'd0;
    cnt4          = 3'd4 - {1'b0, start};
    left_w        = (CW+1)'(LINE_PIXELS) - {1'b0, column_r};
    cnt           = (left_w < (CW+1)'(cnt4)) ? 3'(left_w) : cnt4;
    col_new       = {1'b0, column_r} + (CW+1)'(cnt);
    shifted       = nibble >> start;
    next_addr     = line_addr_r + LINE_STEP + (nsk_r[2] ? SKIP_STEP : '0)
                    + (menu_r ? '0 : line_stride_r);
    if (!mode) begin
      if (!display_on) begin
        if (!off_r) begin
          off_nxt       = 1'b1;
          scan_line_nxt = '0;
        end
        active_nxt = 1'b0;
      end else begin
        if (off_r) begin
          off_nxt = 1'b0;
          sl      = '0;
          mn      = 1'b0;
          la      = screen_base_r;
        end
        nsk           = mn ? 3'd0 : pixel_shift_r;
        scan_line_nxt = sl;
        menu_nxt      = mn;
        line_addr_nxt = la;
        nsk_nxt       = nsk;
        skip_nxt      = nsk[2];
        column_nxt    = '0;
        active_nxt    = 1'b1;
        item.kind     = KIND_FETCH;
        item.addr     = la;
        item.line     = LINE_W'(sl);
      end
    end else if (!off_r && active_r) begin
      item.kind = KIND_GROUP;
      item.addr = line_addr_r;
      item.line = LINE_W'(scan_line_r);
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else begin
        item.col     = COL_W'(column_r);
        item.cnt     = cnt;
        item.gray_en = gray_en_r;
        for (int k = 0; k < LANES; k++) begin
          item.cur[k] = shifted[k] && (3'(k) < cnt);
        end
        column_nxt = CW'(col_new);
        if (col_new >= (CW+1)'(LINE_PIXELS)) begin
          item.line_done  = 1'b1;
          item.frame_done = (scan_line_r == LW'(LINE_COUNT - 1));
          line_addr_nxt   = next_addr;
          if (HW'(scan_line_r) == HW'(main_height_r)) begin
            menu_nxt      = 1'b1;
            line_addr_nxt = menu_start_r;
          end
          scan_line_nxt = scan_line_r + 1'b1;
          phase_nxt     = phase_r;
          if (scan_line_r == LW'(LINE_COUNT - 1)) begin
            scan_line_nxt = '0;
            menu_nxt      = 1'b0;
            line_addr_nxt = screen_base_r;
            phase_nxt     = (phase_r >= 2'd2) ? 2'd0 : phase_r + 2'd1;
          end
          gray_en_nxt = (phase_nxt == 2'd0);
          active_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_base_r <= '0;
      menu_start_r  <= '0;
      line_stride_r <= '0;
      main_height_r <= 6'd63;
      pixel_shift_r <= '0;
      scan_line_r   <= '0;
      menu_r        <= 1'b0;
      line_addr_r   <= '0;
      off_r         <= 1'b0;
      column_r      <= '0;
      nsk_r         <= '0;
      phase_r       <= '0;
      gray_en_r     <= 1'b0;
      active_r      <= 1'b0;
      skip_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_BASE: screen_base_r <= cfg_data;
          REG_MENU_START:  menu_start_r  <= cfg_data;
          REG_LINE_STRIDE: line_stride_r <= cfg_data;
          REG_MAIN_HEIGHT: main_height_r <= cfg_data[5:0];
          REG_PIXEL_SHIFT: pixel_shift_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (acc) begin
        scan_line_r <= scan_line_nxt;
        menu_r      <= menu_nxt;
        line_addr_r <= line_addr_nxt;
        off_r       <= off_nxt;
        column_r    <= column_nxt;
        nsk_r       <= nsk_nxt;
        phase_r     <= phase_nxt;
        gray_en_r   <= gray_en_nxt;
        active_r    <= active_nxt;
        skip_r      <= skip_nxt;
      end
    end
  end
endmodule

// ----- design/lcd_scan_gray_history.sv -----
// Top level of the LCD scan controller with per-pixel gray history.
// Takes one input word per cycle while in_ready is high and returns exactly one result
// word per input word, through the stage 1 register and the output register. The pixel
// history lives in four single-port-write banks interleaved on the low two bits
// of the pixel index, so the up to four consecutive pixels of one group hit four
// different banks: read on acceptance, modified and written back when stage 1 drains.
// Consecutive groups of a line touch disjoint pixels, and a line restart always
// has a tick word in between, so a write back never meets a read of the same
// entry. After reset the block runs a clearing pass over all ceil(LINE_PIXELS *
// LINE_COUNT / 4) bank rows (2096 at the default size) with in_ready low;
// configuration writes are taken during that pass. Configuration should only be
// written while the block is idle.
module lcd_scan_gray_history #(
  parameter int LINE_PIXELS = 131,
  parameter int LINE_COUNT  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [3:0]  in_nibble,
  input  logic        in_display_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [19:0] out_fetch_address,
  output logic [5:0]  out_line_number,
  output logic [7:0]  out_first_column,
  output logic [2:0]  out_pixel_count,
  output logic [1:0]  out_gray_a,
  output logic [1:0]  out_gray_b,
  output logic [1:0]  out_gray_c,
  output logic [1:0]  out_gray_d,
  output logic        out_line_done,
  output logic        out_frame_done
);
  import lsgh_pkg::*;

  localparam int TOTAL = LINE_PIXELS * LINE_COUNT;
  localparam int IW    = $clog2(TOTAL);
  localparam int ROWS  = (TOTAL + LANES - 1) / LANES;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // handshake
  logic acc, out_free, p1_fire;
  // clearing pass
  logic          clearing_r;
  logic [RW-1:0] clr_r;
  // stage 0
  lsgh_item_t    item;
  logic [IW-1:0] idx;
  logic [RW-1:0] raddr [LANES];
  logic          ruse  [LANES];
  // stage 1
  logic          p1_v_r;
  lsgh_item_t    p1_r;
  logic [1:0]    p1_lo_r;
  logic [RW-1:0] p1_addr_r [LANES];
  logic [3:0]    rdata [LANES];
  logic          bwe   [LANES];
  logic [RW-1:0] bwaddr[LANES];
  logic [3:0]    bwdata[LANES];
  logic          pwe   [LANES];
  logic [3:0]    pdata [LANES];
  logic [1:0]    gray  [LANES];
  // output register
  logic          out_valid_r;
  lsgh_item_t    out_r;
  logic [1:0]    out_gray_r [LANES];

  assign out_free = !out_valid_r || out_ready;
  assign p1_fire  = p1_v_r && out_free;
  assign in_ready = !clearing_r && (!p1_v_r || out_free);
  assign acc      = in_valid && in_ready;

  lsgh_scan #(
    .LINE_PIXELS(LINE_PIXELS),
    .LINE_COUNT (LINE_COUNT),
    .IW         (IW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .mode      (in_mode),
    .nibble    (in_nibble),
    .display_on(in_display_on),
    .item      (item),
    .idx       (idx)
  );

  // Bank b holds pixel index i where i mod 4 == b, at row i / 4.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      logic [1:0]  kb;
      logic [IW:0] sum;
      kb       = 2'(b) - idx[1:0];
      sum      = {1'b0, idx} + (IW+1)'(kb);
      raddr[b] = RW'(sum >> 2);
      ruse[b]  = (item.kind == KIND_GROUP) && (3'(kb) < item.cnt);
    end
  end

  // Read-modify-write of each bank, lane k = b - low index bits.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      logic [1:0] kb;
      logic [3:0] old;
      logic       cur;
      logic [1:0] g;
      kb       = 2'(b) - p1_lo_r;
      old      = rdata[b];
      cur      = p1_r.cur[kb];
      g        = p1_r.gray_en ? (2'(cur) + 2'(old[0]) + 2'(old[1])) : old[3:2];
      pwe[b]   = p1_fire && (p1_r.kind == KIND_GROUP) && (3'(kb) < p1_r.cnt);
      pdata[b] = {g, old[0], cur};
      bwe[b]   = clearing_r || pwe[b];
      bwaddr[b] = clearing_r ? clr_r : p1_addr_r[b];
      bwdata[b] = clearing_r ? 4'd0 : pdata[b];
    end
    for (int k = 0; k < LANES; k++) begin
      logic [1:0] bk;
      bk      = p1_lo_r + 2'(k);
      gray[k] = (3'(k) < p1_r.cnt) ? pdata[bk][3:2] : 2'd0;
    end
  end

  for (genvar gb = 0; gb < LANES; gb++) begin : g_bank
    lsgh_bank #(.DEPTH(ROWS), .AW(RW)) u_bank (
      .clk  (clk),
      .we   (bwe[gb]),
      .waddr(bwaddr[gb]),
      .wdata(bwdata[gb]),
      .re   (acc),
      .raddr(raddr[gb]),
      .rdata(rdata[gb])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_r       <= '0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == RW'(ROWS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (acc) begin
        p1_v_r <= 1'b1;
      end else if (p1_fire) begin
        p1_v_r <= 1'b0;
      end
      if (p1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      p1_r    <= item;
      p1_lo_r <= idx[1:0];
      for (int b = 0; b < LANES; b++) begin
        p1_addr_r[b] <= raddr[b];
      end
    end
    if (p1_fire) begin
      out_r <= p1_r;
      for (int k = 0; k < LANES; k++) begin
        out_gray_r[k] <= gray[k];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_fetch_address = out_r.addr;
  assign out_line_number   = out_r.line;
  assign out_first_column  = out_r.col;
  assign out_pixel_count   = out_r.cnt;
  assign out_gray_a        = out_gray_r[0];
  assign out_gray_b        = out_gray_r[1];
  assign out_gray_c        = out_gray_r[2];
  assign out_gray_d        = out_gray_r[3];
  assign out_line_done     = out_r.line_done;
  assign out_frame_done    = out_r.frame_done;

  // no word enters while the store is being cleared
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !acc) else $error("word accepted during clear");

  // a write back never meets a live read of the same entry
  for (genvar ga = 0; ga < LANES; ga++) begin : g_chk
    a_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
      !(acc && ruse[ga] && pwe[ga] && raddr[ga] == p1_addr_r[ga]))
      else $error("read meets pending write back");
  end

  // stage 1 only drains into a free output register
  a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
    p1_fire |=> out_valid_r) else $error("result lost");

  // a finished line is only reported on a pixel group
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.line_done) |-> out_r.kind == KIND_GROUP)
    else $error("line done on non-group word");
endmodule

// ----- dv/tb_lcd_scan_gray_history.sv -----
// Testbench for the LCD scan controller: scoreboarded directed and random scan traffic.
`timescale 1ns / 100ps

module tb_lcd_scan_gray_history;
  import lsgh_pkg::*;

  localparam int PIX_PER_LINE = 131;
  localparam int LINES        = 64;
  localparam int STORE_DEPTH  = PIX_PER_LINE * LINES;
  localparam int ITEMS_PER_PHASE = 590;
  localparam int HOLD_CYCLES  = 400;

  // One expected result word.
  typedef struct packed {
    lsgh_kind_t  kind;
    logic [19:0] addr;
    logic [5:0]  line;
    logic [7:0]  col;
    logic [2:0]  cnt;
    logic [1:0]  ga, gb, gc, gd;
    logic        ld, fd;
  } scan_res_t;

  // Directed stimulus row; fixed rows carry a typed-in answer.
  typedef struct {
    bit          mode;
    bit [3:0]    nib;
    bit          on;
    bit          fixed;
    lsgh_kind_t  kind;
    bit [19:0]   addr;
    bit [5:0]    line;
  } dir_row_t;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        in_valid, in_ready, in_mode, in_display_on;
  logic [3:0]  in_nibble;
  logic        out_valid, out_ready;
  logic [1:0]  out_kind;
  logic [19:0] out_fetch_address;
  logic [5:0]  out_line_number;
  logic [7:0]  out_first_column;
  logic [2:0]  out_pixel_count;
  logic [1:0]  out_gray_a, out_gray_b, out_gray_c, out_gray_d;
  logic        out_line_done, out_frame_done;

  lcd_scan_gray_history dut (.*);

  // ---------------------------------------------------------------------------
  // Scan predictor: register copy, scan state and per-pixel history.
  // ---------------------------------------------------------------------------
  logic [19:0] c_screen, c_menu, c_stride;
  logic [5:0]  c_height;
  logic [2:0]  c_shift;

  int          s_line;
  bit          s_menu, s_off, s_active, s_skip, s_gray_en;
  logic [19:0] s_addr;
  int          s_col;
  logic [2:0]  s_shift;
  int          s_phase;
  logic [3:0]  pix_hist [STORE_DEPTH];

  scan_res_t   expect_q[$];
  int          n_items, n_results, n_lines, n_frames, n_errors;

  int          snd_idle, rcv_idle;
  bit          hold_req;

  function automatic void scan_reset();
    c_screen = '0; c_menu = '0; c_stride = '0; c_height = 6'd63; c_shift = '0;
    s_line = 0; s_menu = 0; s_off = 0; s_active = 0; s_skip = 0; s_gray_en = 0;
    s_addr = '0; s_col = 0; s_shift = '0; s_phase = 0;
    foreach (pix_hist[i]) pix_hist[i] = '0;
  endfunction

  function automatic void scan_config(lsgh_reg_t idx, logic [19:0] val);
    case (idx)
      REG_SCREEN_BASE: c_screen = val;
      REG_MENU_START:  c_menu   = val;
      REG_LINE_STRIDE: c_stride = val;
      REG_MAIN_HEIGHT: c_height = val[5:0];
      REG_PIXEL_SHIFT: c_shift  = val[2:0];
      default: ;
    endcase
  endfunction

  function automatic scan_res_t scan_predict(bit mode, bit [3:0] nib, bit on);
    scan_res_t   r;
    int          start, count, left, idx, sum;
    logic [3:0]  old;
    logic [1:0]  g;
    logic [1:0]  gv [4];
    logic [19:0] nxt;
    r = '0;
    r.kind = KIND_NONE;
    foreach (gv[k]) gv[k] = '0;
    if (!mode) begin
      if (!on) begin
        if (!s_off) begin
          s_off = 1;
          s_line = 0;
        end
        s_active = 0;
        return r;
      end
      // display coming back on restarts the frame at the top
      if (s_off) begin
        s_off = 0; s_line = 0; s_menu = 0; s_addr = c_screen;
      end
      s_shift = s_menu ? 3'd0 : c_shift;
      s_skip = s_shift[2];
      s_col = 0;
      s_active = 1;
      r.kind = KIND_FETCH;
      r.addr = s_addr;
      r.line = s_line[5:0];
      return r;
    end
    if (s_off || !s_active) return r;
    r.kind = KIND_GROUP;
    r.addr = s_addr;
    r.line = s_line[5:0];
    if (s_skip) begin
      s_skip = 0;
      return r;
    end
    start = (s_col == 0) ? int'(s_shift[1:0]) : 0;
    count = 4 - start;
    left = (s_col < PIX_PER_LINE) ? PIX_PER_LINE - s_col : 0;
    if (count > left) count = left;
    r.col = s_col[7:0];
    r.cnt = count[2:0];
    for (int k = 0; k < count; k++) begin
      idx = (s_line * PIX_PER_LINE + s_col + k) % STORE_DEPTH;
      old = pix_hist[idx];
      g = old[3:2];
      if (s_gray_en) begin
        sum = int'(nib[start+k]) + int'(old[0]) + int'(old[1]);
        g = sum[1:0];
      end
      pix_hist[idx] = {g, old[0], nib[start+k]};
      gv[k] = g;
    end
    r.ga = gv[0]; r.gb = gv[1]; r.gc = gv[2]; r.gd = gv[3];
    s_col += count;
    if (s_col >= PIX_PER_LINE) begin
      r.ld = 1;
      r.fd = (s_line + 1 >= LINES);
      // next line address; menu switch after main_height, wrap after last line
      nxt = s_addr + LINE_STEP + (s_shift[2] ? SKIP_STEP : 20'd0);
      if (!s_menu) nxt = nxt + c_stride;
      if (s_line == int'(c_height)) begin
        s_menu = 1;
        nxt = c_menu;
      end
      s_addr = nxt;
      s_line++;
      if (s_line >= LINES) begin
        s_line = 0; s_menu = 0; s_addr = c_screen;
        s_phase = (s_phase >= 2) ? 0 : s_phase + 1;
      end
      s_gray_en = (s_phase == 0);
      s_active = 0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  function automatic void check_field(string name, int e, int a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    scan_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expect_q.size() == 0) begin
        $error("result word with nothing expected (kind %0d)", out_kind);
        n_errors++;
      end else begin
        e = expect_q.pop_front();
        n_results++;
        check_field("kind", e.kind, out_kind);
        check_field("fetch_address", e.addr, out_fetch_address);
        check_field("line_number", e.line, out_line_number);
        check_field("first_column", e.col, out_first_column);
        check_field("pixel_count", e.cnt, out_pixel_count);
        check_field("gray_a", e.ga, out_gray_a);
        check_field("gray_b", e.gb, out_gray_b);
        check_field("gray_c", e.gc, out_gray_c);
        check_field("gray_d", e.gd, out_gray_d);
        check_field("line_done", e.ld, out_line_done);
        check_field("frame_done", e.fd, out_frame_done);
        if (e.ld) n_lines++;
        if (e.fd) n_frames++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  // Offer one word and hold it until taken. Valid is left high on exit so a
  // back-to-back word never drops and raises it in the same step.
  task automatic send_word(bit m, bit [3:0] n, bit o, bit fixed = 0,
                           scan_res_t fixed_res = '0);
    scan_res_t e;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_nibble     <= n;
    in_display_on <= o;
    do @(posedge clk); while (!in_ready);
    e = scan_predict(m, n, o);
    if (fixed) e = fixed_res;
    expect_q.push_back(e);
    n_items++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(lsgh_reg_t idx, logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scan_config(idx, val);
    @(posedge clk);
  endtask

  task automatic load_regs(logic [19:0] sb, logic [19:0] ms, logic [19:0] st,
                           logic [5:0] mh, logic [2:0] ps);
    write_reg(REG_SCREEN_BASE, sb);
    write_reg(REG_MENU_START, ms);
    write_reg(REG_LINE_STRIDE, st);
    write_reg(REG_MAIN_HEIGHT, {14'd0, mh});
    write_reg(REG_PIXEL_SHIFT, {17'd0, ps});
  endtask

  // Random traffic: mostly complete lines, some truncated lines, display
  // off ticks and stray nibbles.
  task automatic random_traffic(int n_words);
    int start_cnt, r, nibs;
    start_cnt = n_items;
    while (n_items - start_cnt < n_words) begin
      r = $urandom_range(99);
      if (r < 85) begin
        send_word(1'b0, 4'($urandom), 1'b1);
        // enough nibbles to finish the line for this shift
        nibs = 33 + (s_shift[2] ? 1 : 0) + ((s_shift[1:0] == 2'd0) ? 0 : 1);
        if (r >= 78) nibs = $urandom_range(1, nibs);
        else if (r >= 72) nibs += 1;
        repeat (nibs) send_word(1'b1, 4'($urandom), 1'($urandom));
      end else if (r < 92) begin
        send_word(1'b0, 4'($urandom), 1'b0);
      end else begin
        send_word(1'b1, 4'($urandom), 1'($urandom));
      end
    end
    drop_valid();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$] = '{
    '{1, 4'hF, 1, 1, KIND_NONE,  20'd0, 6'd0},  // nibble before any tick is stray
    '{0, 4'h0, 1, 1, KIND_FETCH, 20'd0, 6'd0},  // first tick after reset
    '{1, 4'h0, 1, 0, KIND_NONE,  20'd0, 6'd0},
    '{1, 4'hF, 0, 0, KIND_NONE,  20'd0, 6'd0},
    '{1, 4'h5, 1, 0, KIND_NONE,  20'd0, 6'd0},
    '{1, 4'hA, 1, 0, KIND_NONE,  20'd0, 6'd0},
    '{0, 4'hF, 1, 1, KIND_FETCH, 20'd0, 6'd0},  // tick mid-line restarts same line
    '{1, 4'hF, 1, 0, KIND_NONE,  20'd0, 6'd0},
    '{0, 4'h0, 0, 1, KIND_NONE,  20'd0, 6'd0},  // display off
    '{1, 4'h3, 1, 1, KIND_NONE,  20'd0, 6'd0},  // nibble while off
    '{0, 4'h0, 0, 1, KIND_NONE,  20'd0, 6'd0},  // off again
    '{0, 4'h9, 1, 1, KIND_FETCH, 20'd0, 6'd0}   // back on: line 0 at screen base
  };

  initial begin
    scan_res_t fr;
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_mode = 0; in_nibble = '0; in_display_on = 0;
    hold_req = 0;
    n_items = 0; n_results = 0; n_lines = 0; n_frames = 0; n_errors = 0;
    snd_idle = 22; rcv_idle = 55;
    scan_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset register values
    foreach (dir_rows[i]) begin
      fr = '0;
      fr.kind = dir_rows[i].kind;
      fr.addr = dir_rows[i].addr;
      fr.line = dir_rows[i].line;
      send_word(dir_rows[i].mode, dir_rows[i].nib, dir_rows[i].on,
                dir_rows[i].fixed, fr);
    end
    // finish line 0, all ones then all zeros
    repeat (17) send_word(1'b1, 4'hF, 1'b1);
    repeat (17) send_word(1'b1, 4'h0, 1'b1);
    drop_valid();
    wait_drained();

    // phase 1: sender idles lightly, receiver heavily; long output hold-off
    load_regs(20'h12345, 20'hFFFFF, 20'h00000, 6'd63, 3'd0);
    hold_req = 1;
    random_traffic(ITEMS_PER_PHASE);
    wait_drained();

    // phase 2: roles swapped; largest addresses, menu after line 0, max shift
    snd_idle = 55; rcv_idle = 22;
    load_regs(20'hFFFFF, 20'h00000, 20'hFFFFF, 6'd0, 3'd7);
    random_traffic(ITEMS_PER_PHASE);
    wait_drained();

    // phase 3: no idling, random mid-range settings
    snd_idle = 0; rcv_idle = 0;
    load_regs(20'($urandom), 20'($urandom), 20'($urandom),
              6'($urandom_range(1, 62)), 3'($urandom_range(1, 6)));
    random_traffic(ITEMS_PER_PHASE);
    wait_drained();

    repeat (20) @(posedge clk);
    $display("Covered %0d input words, %0d results, %0d completed lines, %0d frames,",
             n_items, n_results, n_lines, n_frames);
    $display("across reset, extreme and random register settings with stalls.");
    if (n_errors == 0 && expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
